// ===== design/ict_pkg.sv =====
// Shared types, codes and sizes for the inode cache table.
package ict_pkg;

  localparam int SLOTS    = 32;
  localparam int REF_BITS = 8;
  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam int QDEPTH   = 2;

  localparam logic [2:0] CMD_GET    = 3'd0;
  localparam logic [2:0] CMD_DUP    = 3'd1;
  localparam logic [2:0] CMD_PUT    = 3'd2;
  localparam logic [2:0] CMD_LOCK   = 3'd3;
  localparam logic [2:0] CMD_UNLOCK = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BUSY     = 3'd2;
  localparam logic [2:0] ST_NOREF    = 3'd3;
  localparam logic [2:0] ST_NOTLOCK  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef enum logic [2:0] {
    OP_GET,
    OP_DUP,
    OP_PUT,
    OP_LOCK,
    OP_UNLOCK,
    OP_NONE
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } bk_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] device_id;
    logic [15:0] inode_number;
    logic [4:0]  slot_index;
    logic        links_zero;
  } item_t;

  typedef struct packed {
    logic [4:0] result_slot;
    logic [2:0] status;
    logic       hit;
    logic       need_load;
    logic       need_free;
    logic [7:0] ref_after;
  } result_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t              op;
    logic             in_range;
    logic [15:0]      device_id;
    logic [15:0]      inode_number;
    logic [4:0]       slot_index;
    logic [SLOT_W-1:0] idx;
    logic             links_zero;
  } work_t;

endpackage

// ===== design/ict_front.sv =====
// Front end: accepts commands, decodes them and queues them for the back end.
module ict_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  ict_pkg::item_t item,
  output logic           wq_empty,
  input  logic           wq_pop,
  output ict_pkg::work_t wq_head
);

  ict_pkg::work_t mem [ict_pkg::QDEPTH];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  ict_pkg::work_t dec;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    dec.device_id    = item.device_id;
    dec.inode_number = item.inode_number;
    dec.slot_index   = item.slot_index;
    dec.idx          = ict_pkg::SLOT_W'(item.slot_index);
    dec.links_zero   = item.links_zero;
    dec.in_range     = (32'(item.slot_index) < 32'(ict_pkg::SLOTS));
    case (item.cmd)
      ict_pkg::CMD_GET:    dec.op = ict_pkg::OP_GET;
      ict_pkg::CMD_DUP:    dec.op = ict_pkg::OP_DUP;
      ict_pkg::CMD_PUT:    dec.op = ict_pkg::OP_PUT;
      ict_pkg::CMD_LOCK:   dec.op = ict_pkg::OP_LOCK;
      ict_pkg::CMD_UNLOCK: dec.op = ict_pkg::OP_UNLOCK;
      default:             dec.op = ict_pkg::OP_NONE;
    endcase
  end

  assign full     = (count == 2'(ict_pkg::QDEPTH));
  assign wq_empty = (count == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = wq_pop && !wq_empty;
  assign wq_head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/ict_outq.sv =====
// Result queue between the back end and the result port.
module ict_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             rq_push,
  input  ict_pkg::result_t rq_data,
  output logic             rq_full,
  output logic             empty,
  input  logic             pop,
  output ict_pkg::result_t result
);

  ict_pkg::result_t mem [ict_pkg::QDEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign rq_full = (count == 2'(ict_pkg::QDEPTH));
  assign empty   = (count == 2'd0);
  assign do_push = rq_push && !rq_full;
  assign do_pop  = pop && !empty;
  assign result  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= rq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== design/ict_back.sv =====
// Back end: slot table, associative lookup and read-modify-write of one slot.
module ict_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             wq_empty,
  output logic             wq_pop,
  input  ict_pkg::work_t   wq_head,
  output logic             rq_push,
  output ict_pkg::result_t rq_data,
  input  logic             rq_full
);

  localparam int SW = ict_pkg::SLOT_W;
  localparam int RB = ict_pkg::REF_BITS;

  logic [15:0]   slot_device [ict_pkg::SLOTS];
  logic [15:0]   slot_inode  [ict_pkg::SLOTS];
  logic [RB-1:0] slot_refs   [ict_pkg::SLOTS];
  logic [ict_pkg::SLOTS-1:0] slot_busy;
  logic [ict_pkg::SLOTS-1:0] slot_valid;

  ict_pkg::bk_state_t state, state_next;

  // lookup results, held for the execute cycle
  ict_pkg::work_t cur;
  logic           hit;
  logic           found;
  logic [SW-1:0]  tgt;

  logic           hit_next;
  logic           free_next;
  logic [SW-1:0]  hit_idx;
  logic [SW-1:0]  free_idx;
  logic           load_lookup;

  logic [RB-1:0]  r;
  logic           b;
  logic           v;
  logic           upd_en;
  logic           key_en;
  logic [RB-1:0]  upd_refs;
  logic           upd_busy;
  logic           upd_valid;
  ict_pkg::result_t res;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ict_pkg::BK_IDLE: if (!wq_empty) state_next = ict_pkg::BK_EXEC;
      ict_pkg::BK_EXEC: if (!rq_full)  state_next = ict_pkg::BK_IDLE;
      default:          state_next = ict_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load_lookup = 1'b0;
    rq_push     = 1'b0;
    case (state)
      ict_pkg::BK_IDLE: load_lookup = !wq_empty;
      ict_pkg::BK_EXEC: rq_push     = !rq_full;
      default: ;
    endcase
  end

  assign wq_pop = load_lookup;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ict_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // parallel key compare and first-free pick; lowest index wins
  always_comb begin
    hit_next  = 1'b0;
    free_next = 1'b0;
    hit_idx   = '0;
    free_idx  = '0;
    for (int i = ict_pkg::SLOTS - 1; i >= 0; i--) begin
      if (slot_refs[i] != '0 && slot_device[i] == wq_head.device_id &&
          slot_inode[i] == wq_head.inode_number) begin
        hit_next = 1'b1;
        hit_idx  = SW'(i);
      end
      if (slot_refs[i] == '0) begin
        free_next = 1'b1;
        free_idx  = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_lookup) begin
      cur   <= wq_head;
      hit   <= hit_next;
      found <= hit_next || free_next;
      if (wq_head.op != ict_pkg::OP_GET) begin
        tgt <= wq_head.idx;
      end else if (hit_next) begin
        tgt <= hit_idx;
      end else begin
        tgt <= free_idx;
      end
    end
  end

  assign r = slot_refs[tgt];
  assign b = slot_busy[tgt];
  assign v = slot_valid[tgt];

  // execute: result and new slot contents
  always_comb begin
    res             = '0;
    res.result_slot = cur.slot_index;
    upd_en          = 1'b0;
    key_en          = 1'b0;
    upd_refs        = r;
    upd_busy        = b;
    upd_valid       = v;
    if (cur.op == ict_pkg::OP_GET) begin
      res.result_slot = 5'(tgt);
      if (hit) begin
        res.hit = 1'b1;
        if (r == ict_pkg::REF_MAX) begin
          res.status    = ict_pkg::ST_OVERFLOW;
          res.ref_after = 8'(r);
        end else begin
          upd_en        = 1'b1;
          upd_refs      = r + RB'(1);
          res.ref_after = 8'(upd_refs);
        end
      end else if (found) begin
        upd_en        = 1'b1;
        key_en        = 1'b1;
        upd_refs      = RB'(1);
        upd_busy      = 1'b0;
        upd_valid     = 1'b0;
        res.ref_after = 8'(upd_refs);
      end else begin
        res.result_slot = 5'd0;
        res.status      = ict_pkg::ST_FULL;
      end
    end else if (cur.op == ict_pkg::OP_NONE) begin
      if (cur.in_range) begin
        res.ref_after = 8'(r);
      end
    end else if (!cur.in_range || r == '0) begin
      res.status = ict_pkg::ST_NOREF;
    end else begin
      res.ref_after = 8'(r);
      case (cur.op)
        ict_pkg::OP_DUP: begin
          if (r == ict_pkg::REF_MAX) begin
            res.status = ict_pkg::ST_OVERFLOW;
          end else begin
            upd_en        = 1'b1;
            upd_refs      = r + RB'(1);
            res.ref_after = 8'(upd_refs);
          end
        end
        ict_pkg::OP_PUT: begin
          if (r == RB'(1) && v && cur.links_zero && b) begin
            res.status = ict_pkg::ST_BUSY;
          end else begin
            upd_en        = 1'b1;
            upd_refs      = r - RB'(1);
            res.ref_after = 8'(upd_refs);
            if (r == RB'(1) && v && cur.links_zero) begin
              upd_busy      = 1'b1;
              res.need_free = 1'b1;
            end
          end
        end
        ict_pkg::OP_LOCK: begin
          if (b) begin
            res.status = ict_pkg::ST_BUSY;
          end else begin
            upd_en        = 1'b1;
            upd_busy      = 1'b1;
            upd_valid     = 1'b1;
            res.need_load = !v;
          end
        end
        ict_pkg::OP_UNLOCK: begin
          if (!b) begin
            res.status = ict_pkg::ST_NOTLOCK;
          end else begin
            upd_en   = 1'b1;
            upd_busy = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign rq_data = res;

  always_ff @(posedge clk) begin
    if (rq_push && key_en) begin
      slot_device[tgt] <= cur.device_id;
      slot_inode[tgt]  <= cur.inode_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ict_pkg::SLOTS; i++) begin
        slot_refs[i] <= '0;
      end
      slot_busy  <= '0;
      slot_valid <= '0;
    end else if (rq_push && upd_en) begin
      slot_refs[tgt]  <= upd_refs;
      slot_busy[tgt]  <= upd_busy;
      slot_valid[tgt] <= upd_valid;
    end
  end

endmodule

// ===== design/refcounted_inode_cache_table.sv =====
// Top level of the reference-counted inode cache table.
//
//   channel   handshake           payload              transfer when
//   command   push / full         item   (item_t)      push && !full
//   result    pop / empty         result (result_t)    pop && !empty
//
// In the back end a command gets the parallel key compare and first-free pick,
// then the read-modify-write of the chosen slot, held while rq_full is set.
// Command and result queues are two deep, so the front keeps taking commands
// while the back end or the result side stalls.
// Synchronous reset clears all counts, busy and valid flags and both queues.
module refcounted_inode_cache_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  ict_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output ict_pkg::result_t result
);

  logic             wq_empty;
  logic             wq_pop;
  ict_pkg::work_t   wq_head;
  logic             rq_push;
  logic             rq_full;
  ict_pkg::result_t rq_data;

  ict_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .wq_empty (wq_empty),
    .wq_pop   (wq_pop),
    .wq_head  (wq_head)
  );

  ict_back u_back (
    .clk      (clk),
    .rst      (rst),
    .wq_empty (wq_empty),
    .wq_pop   (wq_pop),
    .wq_head  (wq_head),
    .rq_push  (rq_push),
    .rq_data  (rq_data),
    .rq_full  (rq_full)
  );

  ict_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .rq_push (rq_push),
    .rq_data (rq_data),
    .rq_full (rq_full),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
